// ----- design/midi_track_event_parser_defines.svh -----
// Assertion macros shared by the MIDI track event parser RTL.
// Depends on nothing; the asserting module must have clk_i and rst_ni in scope.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

// Concurrent check sampled on the rising clock edge, suspended while in reset.
`define MTEP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mtep assertion failed");

// Concurrent check that also holds during reset.
`define MTEP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mtep assertion failed");

`endif

// ----- design/mtep_pkg.sv -----
// Package for the MIDI track event parser: widths, codes, parse phases and types.
// Depends on nothing.
`default_nettype none

package mtep_pkg;

  // Width of the tick counter and the delta accumulator.
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned ABS_BITS  = 32;

  // Byte values with a special meaning in the track stream.
  localparam logic [7:0] STATUS_MIN   = 8'h80;
  localparam logic [7:0] SYSTEM_MIN   = 8'hF0;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [3:0] PROG_CHANGE  = 4'hC;
  localparam logic [3:0] CHAN_PRESS   = 4'hD;

  // Maximum number of bytes in a delta time.
  localparam logic [2:0] DELTA_MAX_BYTES = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_NO_STATUS  = 2'd1;
  localparam logic [1:0] ERR_DELTA_LONG = 2'd2;

  // Parse phase, one-hot.
  typedef enum logic [8:0] {
    PH_DELTA     = 9'b000000001,
    PH_STATUS    = 9'b000000010,
    PH_DATA1     = 9'b000000100,
    PH_DATA2     = 9'b000001000,
    PH_META_TYPE = 9'b000010000,
    PH_META_LEN  = 9'b000100000,
    PH_META_SKIP = 9'b001000000,
    PH_SYSEX     = 9'b010000000,
    PH_HALT      = 9'b100000000
  } phase_e;

  // One result beat.
  typedef struct packed {
    logic [ABS_BITS-1:0] abs_time;
    logic [7:0]          status_byte;
    logic [7:0]          data_one;
    logic [7:0]          data_two;
    logic [1:0]          data_count;
    logic [1:0]          kind;
    logic [1:0]          error_code;
  } event_t;

  // Channel messages with a single data byte.
  function automatic logic one_data_byte(input logic [7:0] status);
    return (status[7:4] == PROG_CHANGE) || (status[7:4] == CHAN_PRESS);
  endfunction

endpackage

`default_nettype wire

// ----- design/mtep_byte_if.sv -----
// Input channel of the MIDI track event parser: one track byte per beat.
// Depends on mtep_pkg.
`default_nettype none

interface mtep_byte_if import mtep_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_track;

  modport source (output valid, output data_byte, output new_track, input ready);
  modport sink   (input valid, input data_byte, input new_track, output ready);
endinterface

`default_nettype wire

// ----- design/mtep_event_if.sv -----
// Output channel of the MIDI track event parser: one decoded event per beat.
// Depends on mtep_pkg.
`default_nettype none

interface mtep_event_if import mtep_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ABS_BITS-1:0] abs_time;
  logic [7:0]          status_byte;
  logic [7:0]          data_one;
  logic [7:0]          data_two;
  logic [1:0]          data_count;
  logic [1:0]          kind;
  logic [1:0]          error_code;

  modport source (output valid, output abs_time, output status_byte, output data_one,
                  output data_two, output data_count, output kind, output error_code,
                  input ready);
  modport sink   (input valid, input abs_time, input status_byte, input data_one,
                  input data_two, input data_count, input kind, input error_code,
                  output ready);
endinterface

`default_nettype wire

// ----- design/midi_track_event_parser.sv -----
// MIDI track event parser: top level with the parse state machine and result register.
// Depends on mtep_pkg, mtep_byte_if, mtep_event_if and midi_track_event_parser_defines.svh.
//
// Usage:
//   in_i carries the bytes of a Standard MIDI File track, one byte per beat. A beat
//   with new_track set starts a track: the tick count and all parse state are cleared
//   and its byte is ignored. out_o carries one beat per channel or system event, one
//   for the end of the track (meta 2F) and one for an error; meta events and sysex
//   produce nothing. After an end of track or an error every byte is ignored until
//   the next new_track beat.
//   Latency: a result appears on out_o in the cycle after the byte that completes it.
//   Throughput: one byte per cycle unless out_o stalls; each byte step is a single
//   pass through the phase logic and the tick adder, ending in the output register.
//   Stall: while a result waits on out_o with ready low, in_i.ready is low; it is high
//   again in the cycle in which that result is taken, so no cycle is lost.
//   Reset: rst_ni is asynchronous and active low; it empties the output register and
//   puts the parser in the delta time phase with a zero tick count and no running
//   status, as a new_track beat does.
`default_nettype none
`include "midi_track_event_parser_defines.svh"

module midi_track_event_parser import mtep_pkg::*; (
  input  wire           clk_i,
  input  wire           rst_ni,
  mtep_byte_if.sink     in_i,
  mtep_event_if.source  out_o
);

  // Parse state.
  phase_e                phase_q, phase_d;
  logic [7:0]            run_status_q, run_status_d;
  logic [TIME_BITS-1:0]  delta_q, delta_d;
  logic [2:0]            delta_cnt_q, delta_cnt_d;
  logic [TIME_BITS-1:0]  tick_q, tick_d;
  logic [7:0]            first_data_q, first_data_d;
  logic [7:0]            meta_kind_q, meta_kind_d;
  logic [7:0]            meta_rem_q, meta_rem_d;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  event_t                out_ev_q;

  logic                  in_accept;
  logic                  emit;
  event_t                ev;
  logic [TIME_BITS-1:0]  delta_shift;
  logic [2:0]            delta_cnt_inc;
  logic [7:0]            meta_rem_dec;
  logic [7:0]            b;

  // A new byte is taken whenever the result register is empty or being emptied.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;

  assign delta_shift   = {delta_q[TIME_BITS-8:0], b[6:0]};
  assign delta_cnt_inc = delta_cnt_q + 3'd1;
  assign meta_rem_dec  = meta_rem_q - 8'd1;

  // Byte step: next parse state and the result, if any.
  always_comb begin
    phase_d      = phase_q;
    run_status_d = run_status_q;
    delta_d      = delta_q;
    delta_cnt_d  = delta_cnt_q;
    tick_d       = tick_q;
    first_data_d = first_data_q;
    meta_kind_d  = meta_kind_q;
    meta_rem_d   = meta_rem_q;
    emit         = 1'b0;
    ev           = '{abs_time:    ABS_BITS'(tick_q),
                     status_byte: 8'h00,
                     data_one:    8'h00,
                     data_two:    8'h00,
                     data_count:  2'd0,
                     kind:        KIND_EVENT,
                     error_code:  ERR_NONE};

    if (in_i.new_track) begin
      phase_d      = PH_DELTA;
      run_status_d = 8'h00;
      delta_d      = '0;
      delta_cnt_d  = 3'd0;
      tick_d       = '0;
      first_data_d = 8'h00;
      meta_kind_d  = 8'h00;
      meta_rem_d   = 8'h00;
    end else begin
      unique case (phase_q) inside
        PH_DELTA: begin
          if (b < STATUS_MIN) begin
            tick_d      = tick_q + delta_shift;
            delta_d     = '0;
            delta_cnt_d = 3'd0;
            phase_d     = PH_STATUS;
          end else begin
            delta_d     = delta_shift;
            delta_cnt_d = delta_cnt_inc;
            if (delta_cnt_inc >= DELTA_MAX_BYTES) begin
              phase_d       = PH_HALT;
              emit          = 1'b1;
              ev.kind       = KIND_ERROR;
              ev.error_code = ERR_DELTA_LONG;
            end
          end
        end

        PH_STATUS: begin
          if (b >= STATUS_MIN) begin
            if (b < SYSTEM_MIN) begin
              run_status_d = b;
              phase_d      = PH_DATA1;
            end else begin
              // Every system status cancels the running status.
              run_status_d = 8'h00;
              if (b == META_STATUS) begin
                phase_d = PH_META_TYPE;
              end else if (b == SYSEX_START) begin
                phase_d = PH_SYSEX;
              end else begin
                phase_d        = PH_DELTA;
                emit           = 1'b1;
                ev.status_byte = b;
              end
            end
          end else if (run_status_q == 8'h00) begin
            phase_d       = PH_HALT;
            emit          = 1'b1;
            ev.kind       = KIND_ERROR;
            ev.error_code = ERR_NO_STATUS;
          end else begin
            // Running status: this byte is already the first data byte.
            first_data_d = b;
            if (one_data_byte(run_status_q)) begin
              phase_d        = PH_DELTA;
              emit           = 1'b1;
              ev.status_byte = run_status_q;
              ev.data_one    = b;
              ev.data_count  = 2'd1;
            end else begin
              phase_d = PH_DATA2;
            end
          end
        end

        PH_DATA1: begin
          first_data_d = b;
          if (one_data_byte(run_status_q)) begin
            phase_d        = PH_DELTA;
            emit           = 1'b1;
            ev.status_byte = run_status_q;
            ev.data_one    = b;
            ev.data_count  = 2'd1;
          end else begin
            phase_d = PH_DATA2;
          end
        end

        PH_DATA2: begin
          phase_d        = PH_DELTA;
          emit           = 1'b1;
          ev.status_byte = run_status_q;
          ev.data_one    = first_data_q;
          ev.data_two    = b;
          ev.data_count  = 2'd2;
        end

        PH_META_TYPE: begin
          meta_kind_d = b;
          phase_d     = PH_META_LEN;
        end

        PH_META_LEN, PH_META_SKIP: begin
          // Length byte, then count down the meta payload.
          if (phase_q == PH_META_LEN) begin
            meta_rem_d = b;
          end else begin
            meta_rem_d = meta_rem_dec;
          end
          if (meta_rem_d != 8'h00) begin
            phase_d = PH_META_SKIP;
          end else if (meta_kind_q == META_EOT) begin
            phase_d        = PH_HALT;
            emit           = 1'b1;
            ev.status_byte = META_STATUS;
            ev.data_one    = META_EOT;
            ev.data_count  = 2'd1;
            ev.kind        = KIND_END;
          end else begin
            phase_d = PH_DELTA;
          end
        end

        PH_SYSEX: begin
          if (b == SYSEX_END) begin
            phase_d = PH_DELTA;
          end
        end

        PH_HALT: begin
          phase_d = PH_HALT;
        end

        default: begin
          phase_d = PH_HALT;
        end
      endcase
    end
  end

  // The result register fills on an accepted byte that completes an event and empties when its result is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DELTA;
      run_status_q <= 8'h00;
      delta_q      <= '0;
      delta_cnt_q  <= 3'd0;
      tick_q       <= '0;
      first_data_q <= 8'h00;
      meta_kind_q  <= 8'h00;
      meta_rem_q   <= 8'h00;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        phase_q      <= phase_d;
        run_status_q <= run_status_d;
        delta_q      <= delta_d;
        delta_cnt_q  <= delta_cnt_d;
        tick_q       <= tick_d;
        first_data_q <= first_data_d;
        meta_kind_q  <= meta_kind_d;
        meta_rem_q   <= meta_rem_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      out_ev_q <= ev;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.abs_time    = out_ev_q.abs_time;
  assign out_o.status_byte = out_ev_q.status_byte;
  assign out_o.data_one    = out_ev_q.data_one;
  assign out_o.data_two    = out_ev_q.data_two;
  assign out_o.data_count  = out_ev_q.data_count;
  assign out_o.kind        = out_ev_q.kind;
  assign out_o.error_code  = out_ev_q.error_code;

  // A held result must block the input side.
  `MTEP_ASSERT(a_stall_blocks_input, (out_valid_q && !out_o.ready) |-> !in_i.ready)
  // Error beats carry a code and no data bytes.
  `MTEP_ASSERT(a_error_shape, (out_valid_q && (out_ev_q.kind == KIND_ERROR)) |->
    ((out_ev_q.error_code != ERR_NONE) && (out_ev_q.data_count == 2'd0)))
  // Once halted, only a track start leaves the halt phase.
  `MTEP_ASSERT(a_halt_sticks, (in_accept && !in_i.new_track && (phase_q == PH_HALT)) |=>
    (phase_q == PH_HALT))
  // End of track and errors leave the parser halted.
  `MTEP_ASSERT(a_final_halts, (in_accept && emit && (ev.kind != KIND_EVENT)) |=>
    (phase_q == PH_HALT))

endmodule

`default_nettype wire

// ----- dv/midi_track_event_parser_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the MIDI track event parser: watches both channels, predicts each event.
// Depends on mtep_pkg; instantiated beside the block by midi_track_event_parser_tb.

module midi_track_event_parser_checker import mtep_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_ready_i,
  input  wire  [7:0] in_byte_i,
  input  wire        in_new_track_i,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  event_t     out_event_i,
  output int         fail_count_o,
  output int         pending_o
);

  // Parser state as the block should hold it.
  phase_e               parse_phase;
  logic [7:0]           run_status;
  logic [7:0]           held_data;
  logic [7:0]           meta_type;
  logic [7:0]           meta_left;
  logic [TIME_BITS-1:0] delta_sum;
  logic [TIME_BITS-1:0] ticks;
  logic [2:0]           delta_bytes;

  // Events still owed by the block, oldest first.
  event_t               owed_events[$];

  // Stamps an event with the current tick count.
  function automatic event_t stamp_event(input logic [7:0] st, input logic [7:0] d1,
                                         input logic [7:0] d2, input logic [1:0] cnt,
                                         input logic [1:0] knd, input logic [1:0] err);
    return {ticks[ABS_BITS-1:0], st, d1, d2, cnt, knd, err};
  endfunction

  task automatic clear_parser();
    parse_phase = PH_DELTA;
    run_status  = '0;
    held_data   = '0;
    meta_type   = '0;
    meta_left   = '0;
    delta_sum   = '0;
    ticks       = '0;
    delta_bytes = '0;
  endtask

  // First data byte of a channel message; programme change and channel pressure end here.
  task automatic take_first_data(input logic [7:0] b, output bit produced, output event_t ev);
    held_data = b;
    produced  = 1'b0;
    ev        = '0;
    if (run_status[7:4] == PROG_CHANGE || run_status[7:4] == CHAN_PRESS) begin
      parse_phase = PH_DELTA;
      produced    = 1'b1;
      ev          = stamp_event(run_status, b, 8'h00, 2'd1, KIND_EVENT, ERR_NONE);
    end else begin
      parse_phase = PH_DATA2;
    end
  endtask

  // A meta event has been skipped; only end of track gives a result.
  task automatic finish_meta(output bit produced, output event_t ev);
    produced = 1'b0;
    ev       = '0;
    if (meta_type == META_EOT) begin
      parse_phase = PH_HALT;
      produced    = 1'b1;
      ev          = stamp_event(META_STATUS, META_EOT, 8'h00, 2'd1, KIND_END, ERR_NONE);
    end else begin
      parse_phase = PH_DELTA;
    end
  endtask

  // Advances the parser by one accepted byte beat.
  task automatic parse_byte(input logic [7:0] b, input logic nt,
                            output bit produced, output event_t ev);
    produced = 1'b0;
    ev       = '0;
    if (nt) begin
      clear_parser();
    end else begin
      case (parse_phase)
        PH_DELTA: begin
          delta_sum   = (delta_sum << 7) | TIME_BITS'(b[6:0]);
          delta_bytes = delta_bytes + 3'd1;
          if (!b[7]) begin
            ticks       = ticks + delta_sum;
            delta_sum   = '0;
            delta_bytes = '0;
            parse_phase = PH_STATUS;
          end else if (delta_bytes >= DELTA_MAX_BYTES) begin
            parse_phase = PH_HALT;
            produced    = 1'b1;
            ev          = stamp_event(8'h00, 8'h00, 8'h00, 2'd0, KIND_ERROR, ERR_DELTA_LONG);
          end
        end
        PH_STATUS: begin
          if (b >= STATUS_MIN) begin
            if (b < SYSTEM_MIN) begin
              run_status  = b;
              parse_phase = PH_DATA1;
            end else begin
              // Every system status drops the running status.
              run_status = '0;
              if (b == META_STATUS) begin
                parse_phase = PH_META_TYPE;
              end else if (b == SYSEX_START) begin
                parse_phase = PH_SYSEX;
              end else begin
                parse_phase = PH_DELTA;
                produced    = 1'b1;
                ev          = stamp_event(b, 8'h00, 8'h00, 2'd0, KIND_EVENT, ERR_NONE);
              end
            end
          end else if (run_status == '0) begin
            parse_phase = PH_HALT;
            produced    = 1'b1;
            ev          = stamp_event(8'h00, 8'h00, 8'h00, 2'd0, KIND_ERROR, ERR_NO_STATUS);
          end else begin
            take_first_data(b, produced, ev);
          end
        end
        PH_DATA1: begin
          take_first_data(b, produced, ev);
        end
        PH_DATA2: begin
          parse_phase = PH_DELTA;
          produced    = 1'b1;
          ev          = stamp_event(run_status, held_data, b, 2'd2, KIND_EVENT, ERR_NONE);
        end
        PH_META_TYPE: begin
          meta_type   = b;
          parse_phase = PH_META_LEN;
        end
        PH_META_LEN: begin
          meta_left = b;
          if (b == 8'h00) begin
            finish_meta(produced, ev);
          end else begin
            parse_phase = PH_META_SKIP;
          end
        end
        PH_META_SKIP: begin
          meta_left = meta_left - 8'd1;
          if (meta_left == 8'h00) begin
            finish_meta(produced, ev);
          end
        end
        PH_SYSEX: begin
          if (b == SYSEX_END) begin
            parse_phase = PH_DELTA;
          end
        end
        default: begin
          parse_phase = PH_HALT;
        end
      endcase
    end
  endtask

  // Compare each accepted event beat first, then predict from the accepted byte beat.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    bit     produced;
    event_t want;
    if (!rst_ni) begin
      clear_parser();
      owed_events.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_events.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("unexpected event at %0t: time %h status %h data %h %h kind %0d",
                     $realtime, out_event_i.abs_time, out_event_i.status_byte,
                     out_event_i.data_one, out_event_i.data_two, out_event_i.kind);
          end
        end else begin
          want = owed_events.pop_front();
          if (out_event_i.abs_time    !== want.abs_time    ||
              out_event_i.status_byte !== want.status_byte ||
              out_event_i.data_one    !== want.data_one    ||
              out_event_i.data_two    !== want.data_two    ||
              out_event_i.data_count  !== want.data_count  ||
              out_event_i.kind        !== want.kind        ||
              out_event_i.error_code  !== want.error_code) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch at %0t: want t %h st %h d %h %h n %0d k %0d e %0d",
                       $realtime, want.abs_time, want.status_byte, want.data_one,
                       want.data_two, want.data_count, want.kind, want.error_code);
              $display("  got t %h st %h d %h %h n %0d k %0d e %0d",
                       out_event_i.abs_time, out_event_i.status_byte, out_event_i.data_one,
                       out_event_i.data_two, out_event_i.data_count, out_event_i.kind,
                       out_event_i.error_code);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        parse_byte(in_byte_i, in_new_track_i, produced, want);
        if (produced) begin
          owed_events.push_back(want);
        end
      end
    end
    pending_o = owed_events.size();
  end

endmodule

// ----- dv/midi_track_event_parser_tb.sv -----
`timescale 1ns / 100ps
// Top of the MIDI track event parser testbench: clock, reset, track byte stimulus, verdict.
// Depends on mtep_pkg, both channel interfaces, the block and midi_track_event_parser_checker.

module midi_track_event_parser_tb;
  import mtep_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int CALM_FROM    = 470;
  localparam int HOLD_FROM    = 200;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 5;

  logic       clk_i;
  logic       rst_ni;
  int         fail_count;
  int         pending;

  // Stimulus control shared with the receiver.
  int         items_done;
  bit         calm;
  bit         gaps_on;
  bit         stall_req;
  bit         hold_done;

  // The generator's own view of the running status, to build well-formed tracks.
  bit         gen_running;
  logic [7:0] gen_status;

  mtep_byte_if  in_ch();
  mtep_event_if out_ch();

  midi_track_event_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  midi_track_event_parser_checker event_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch.valid),
    .in_ready_i     (in_ch.ready),
    .in_byte_i      (in_ch.data_byte),
    .in_new_track_i (in_ch.new_track),
    .out_valid_i    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .out_event_i    ({out_ch.abs_time, out_ch.status_byte, out_ch.data_one, out_ch.data_two,
                      out_ch.data_count, out_ch.kind, out_ch.error_code}),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("midi_track_event_parser test failed");
    $finish;
  end

  // Receiver: random stall bursts, long open stretches, and one long hold-off on request.
  initial begin
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // Offers one byte beat, with an occasional gap before it, and waits for acceptance.
  task automatic send_byte(input logic [7:0] b, input bit nt, input bit live);
    if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.new_track <= nt;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (live) begin
      items_done++;
    end
  endtask

  // Mostly short deltas; now and then up to five bytes, which makes the tick count wrap.
  function automatic int delta_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 1;
    if (r < 80) return 2;
    if (r < 90) return 3;
    if (r < 96) return 4;
    return 5;
  endfunction

  function automatic logic [7:0] data_value();
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic send_delta(input int n);
    int i;
    for (i = 1; i <= n; i++) begin
      send_byte({i < n, 7'($urandom)}, 1'b0, 1'b1);
    end
  endtask

  // Bytes after an end of track or an error; the block should ignore them.
  task automatic send_noise();
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  // One well-formed event: channel message, system status, meta or sysex.
  task automatic send_event();
    int         pick;
    int         n_data;
    int         len;
    logic [7:0] b;
    send_delta(delta_len());
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      if (!gen_running || $urandom_range(0, 2) == 0) begin
        b = 8'($urandom_range(8'h80, 8'hEF));
        send_byte(b, 1'b0, 1'b1);
        gen_running = 1'b1;
        gen_status  = b;
      end
      n_data = (gen_status[7:4] == PROG_CHANGE || gen_status[7:4] == CHAN_PRESS) ? 1 : 2;
      repeat (n_data) send_byte(data_value(), 1'b0, 1'b1);
    end else if (pick < 75) begin
      send_byte(8'($urandom_range(8'hF1, 8'hFE)), 1'b0, 1'b1);
      gen_running = 1'b0;
    end else if (pick < 88) begin
      send_byte(META_STATUS, 1'b0, 1'b1);
      b = 8'($urandom);
      if (b == META_EOT) begin
        b = 8'h01;
      end
      send_byte(b, 1'b0, 1'b1);
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
      send_byte(8'(len), 1'b0, 1'b1);
      repeat (len) send_byte(8'($urandom), 1'b0, 1'b1);
      gen_running = 1'b0;
    end else begin
      send_byte(SYSEX_START, 1'b0, 1'b1);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom);
        if (b == SYSEX_END) begin
          b = 8'h00;
        end
        send_byte(b, 1'b0, 1'b1);
      end
      send_byte(SYSEX_END, 1'b0, 1'b1);
      gen_running = 1'b0;
    end
  endtask

  // One random track: mostly well-formed, some broken or pure noise.
  task automatic run_track();
    int mode;
    int len;
    mode    = $urandom_range(0, 19);
    gaps_on = ($urandom_range(0, 3) != 0);
    send_byte(8'($urandom), 1'b1, 1'b1);
    gen_running = 1'b0;
    if (mode == 0) begin
      // A data byte straight after the delta, with no status seen yet.
      send_delta(delta_len());
      send_byte(8'($urandom_range(0, 127)), 1'b0, 1'b1);
      send_noise();
    end else if (mode == 1) begin
      // Five delta bytes that all ask for more.
      repeat (5) send_byte({1'b1, 7'($urandom)}, 1'b0, 1'b1);
      send_noise();
    end else if (mode == 2) begin
      repeat ($urandom_range(1, 20)) send_byte(8'($urandom), 1'b0, 1'b1);
    end else begin
      if (!hold_done && items_done >= HOLD_FROM) begin
        hold_done = 1'b1;
        stall_req = 1'b1;
      end
      repeat ($urandom_range(1, 25)) send_event();
      // A track cut short is ended by the next new-track beat.
      if (mode != 3) begin
        send_delta(delta_len());
        send_byte(META_STATUS, 1'b0, 1'b1);
        send_byte(META_EOT, 1'b0, 1'b1);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        send_byte(8'(len), 1'b0, 1'b1);
        repeat (len) send_byte(8'($urandom), 1'b0, 1'b1);
        send_noise();
      end
    end
  endtask

  // Directed opening: extremes, running status, every message class and both errors.
  task automatic run_directed();
    logic [8:0] beats[$];
    int         i;
    beats = '{
      {1'b1, 8'h00},
      // Longest four-byte delta, then a note-on with extreme data bytes.
      {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'h7F},
      {1'b0, 8'h90}, {1'b0, 8'h00}, {1'b0, 8'h7F},
      // Running status, two data bytes.
      {1'b0, 8'h00}, {1'b0, 8'h3C}, {1'b0, 8'h00},
      // Programme change, then running status with one data byte.
      {1'b0, 8'h00}, {1'b0, 8'hC5}, {1'b0, 8'h7F},
      {1'b0, 8'h00}, {1'b0, 8'h12},
      // System status with no data, empty sysex, a short meta event.
      {1'b0, 8'h00}, {1'b0, 8'hF8},
      {1'b0, 8'h00}, {1'b0, SYSEX_START}, {1'b0, SYSEX_END},
      {1'b0, 8'h00}, {1'b0, META_STATUS}, {1'b0, 8'h01}, {1'b0, 8'h01}, {1'b0, 8'h41},
      // Data bytes with the top bit set are taken as they are.
      {1'b0, 8'h00}, {1'b0, 8'hB0}, {1'b0, 8'h80}, {1'b0, 8'hFF},
      // End of track, then a byte that must be ignored.
      {1'b0, 8'h00}, {1'b0, META_STATUS}, {1'b0, META_EOT}, {1'b0, 8'h00},
      {1'b0, 8'h90},
      // Data byte with no running status.
      {1'b1, 8'hFF}, {1'b0, 8'h00}, {1'b0, 8'h40},
      // Delta time too long.
      {1'b1, 8'h00},
      {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80}
    };
    for (i = 0; i < beats.size(); i++) begin
      send_byte(beats[i][7:0], beats[i][8], 1'b1);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.new_track <= 1'b0;
    rst_ni          <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    gaps_on = 1'b1;
    run_directed();
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      calm = (items_done >= CALM_FROM);
      run_track();
    end
    in_ch.valid <= 1'b0;

    // Let every owed event arrive, then drain quietly before the verdict.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("midi_track_event_parser test passed");
    end else begin
      $display("midi_track_event_parser test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/mtep_pkg.sv
design/mtep_byte_if.sv
design/mtep_event_if.sv
design/midi_track_event_parser.sv
dv/midi_track_event_parser_checker.sv
dv/midi_track_event_parser_tb.sv
